>>> rtl/rsa_pkg.sv
// Package for the rectangle shelf allocator: shared types and constants.
// Used by the controller, the datapath and the top level.
`default_nettype none
package rsa_pkg;

    localparam int unsigned COORD_W = 13;
    localparam logic [COORD_W-1:0] SAT_COORD = 13'h1FFF;

    localparam logic [1:0] CFG_ATLAS_WIDTH  = 2'd0;
    localparam logic [1:0] CFG_ATLAS_HEIGHT = 2'd1;
    localparam logic [1:0] CFG_MIN_FREE     = 2'd2;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SCAN,
        ST_SCAN_WAIT,
        ST_DECIDE,
        ST_ADD_A,
        ST_ADD_B,
        ST_SHIFT_RD,
        ST_SHIFT_WR,
        ST_SHELF,
        ST_RETRY,
        ST_OUT
    } t_state;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load_req;
        logic scan_start;
        logic scan_step;
        logic add_a;
        logic add_b;
        logic shift_rd;
        logic shift_wr;
        logic shelf_place;
        logic shelf_close;
        logic set_grant;
        logic set_refuse;
    } t_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic scan_hit;
        logic scan_end;
        logic too_tall;
        logic fits_shelf;
        logic shelf_open;
        logic full_after_close;
        logic shift_done;
    } t_status;

endpackage
`default_nettype wire

>>> rtl/rsa_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none
module rsa_ram #(
    parameter int unsigned WIDTH = 13,
    parameter int unsigned DEPTH = 32
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule
`default_nettype wire

>>> rtl/rsa_ctrl.sv
// Controller state machine of the rectangle shelf allocator.
// Depends on rsa_pkg; drives the datapath by command struct.
`default_nettype none
module rsa_ctrl
    import rsa_pkg::*;
(
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire logic    i_in_valid,
    output logic         o_in_ready,
    output logic         o_out_valid,
    input  wire logic    i_out_ready,
    input  wire t_status i_status,
    output t_cmd         o_cmd
);
    t_state r_state, n_state;
    logic   r_attempt, n_attempt;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_attempt <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_attempt <= n_attempt;
        end
    end

    always_comb begin
        n_state   = r_state;
        n_attempt = r_attempt;
        unique case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    n_state   = ST_SCAN;
                    n_attempt = 1'b0;
                end
            end
            ST_SCAN:      n_state = ST_SCAN_WAIT;
            ST_SCAN_WAIT: begin
                if (i_status.scan_hit) begin
                    n_state = ST_ADD_A;
                end else if (i_status.scan_end) begin
                    n_state = ST_DECIDE;
                end
            end
            ST_ADD_A:     n_state = ST_ADD_B;
            ST_ADD_B:     n_state = ST_SHIFT_RD;
            ST_SHIFT_RD:  n_state = i_status.shift_done ? ST_OUT : ST_SHIFT_WR;
            ST_SHIFT_WR:  n_state = ST_SHIFT_RD;
            ST_DECIDE: begin
                if (i_status.too_tall) begin
                    n_state = ST_OUT;
                end else if (i_status.fits_shelf) begin
                    n_state = ST_OUT;
                end else if (!i_status.shelf_open) begin
                    n_state = ST_OUT;
                end else begin
                    n_state = ST_SHELF;
                end
            end
            ST_SHELF: begin
                if (i_status.full_after_close || r_attempt) begin
                    n_state = ST_OUT;
                end else begin
                    n_state   = ST_RETRY;
                    n_attempt = 1'b1;
                end
            end
            ST_RETRY:     n_state = ST_SCAN_WAIT;
            ST_OUT:       if (i_out_ready) n_state = ST_IDLE;
            default:      n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        o_cmd       = '0;
        o_in_ready  = 1'b0;
        o_out_valid = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                o_in_ready       = 1'b1;
                o_cmd.load_req   = i_in_valid;
            end
            ST_SCAN:      o_cmd.scan_start = 1'b1;
            ST_SCAN_WAIT: o_cmd.scan_step  = !i_status.scan_hit && !i_status.scan_end;
            ST_ADD_A: begin
                o_cmd.add_a     = 1'b1;
                o_cmd.set_grant = 1'b1;
            end
            ST_ADD_B:     o_cmd.add_b    = 1'b1;
            ST_SHIFT_RD:  o_cmd.shift_rd = 1'b1;
            ST_SHIFT_WR:  o_cmd.shift_wr = 1'b1;
            ST_DECIDE: begin
                if (i_status.too_tall || (!i_status.fits_shelf && !i_status.shelf_open)) begin
                    o_cmd.set_refuse = 1'b1;
                end else if (i_status.fits_shelf) begin
                    o_cmd.shelf_place = 1'b1;
                end
            end
            ST_SHELF: begin
                o_cmd.shelf_close = 1'b1;
                // Either the atlas is full, or the single retry is already used.
                o_cmd.set_refuse  = i_status.full_after_close || r_attempt;
            end
            ST_RETRY:     o_cmd.scan_start = 1'b1;
            ST_OUT:       o_out_valid = 1'b1;
            default:      ;
        endcase
    end

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_ready |-> !o_out_valid)
        else $error("ready and result valid together");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_SHELF && r_attempt) |=> r_state == ST_OUT)
        else $error("more than one shelf retry");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_ready) |=> o_out_valid)
        else $error("result dropped");
endmodule
`default_nettype wire

>>> rtl/rsa_dpath.sv
// Datapath of the rectangle shelf allocator: free-cell table, brush, shelf.
// Depends on rsa_pkg and rsa_ram; commanded by rsa_ctrl.
`default_nettype none
module rsa_dpath
    import rsa_pkg::*;
#(
    parameter int unsigned FREE_ENTRIES = 32
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire t_cmd               i_cmd,
    output t_status                 o_status,
    input  wire logic [COORD_W-1:0] i_req_width,
    input  wire logic [COORD_W-1:0] i_req_height,
    input  wire logic               i_cfg_we,
    input  wire logic [1:0]         i_cfg_index,
    input  wire logic [COORD_W-1:0] i_cfg_data,
    output logic                    o_granted,
    output logic [COORD_W-1:0]      o_left_edge,
    output logic [COORD_W-1:0]      o_right_edge,
    output logic [COORD_W-1:0]      o_top_edge,
    output logic [COORD_W-1:0]      o_bottom_edge
);
    localparam int unsigned AW = $clog2(FREE_ENTRIES);
    localparam int unsigned CW = $clog2(FREE_ENTRIES + 1);
    localparam int unsigned RW = 4 * COORD_W;
    localparam logic [CW-1:0] FULL = CW'(FREE_ENTRIES);
    localparam int unsigned SW = COORD_W + 2;

    logic [COORD_W-1:0] r_atlas_w, r_atlas_h, r_min_free;
    logic [COORD_W-1:0] r_w, r_h;
    logic [CW-1:0]      r_count;
    logic [COORD_W-1:0] r_brush_x, r_brush_y, r_shelf_h;
    logic               r_shelf_open;
    logic [CW-1:0]      r_idx;
    logic               r_rd_valid;
    logic [COORD_W-1:0] r_hx, r_hy, r_hw, r_hh;
    logic [CW-1:0]      r_hit_idx;
    logic               r_granted;
    logic [COORD_W-1:0] r_left, r_top;

    logic               we;
    logic [AW-1:0]      waddr, raddr;
    logic [RW-1:0]      wdata, rdata;
    logic [COORD_W-1:0] rx, ry, rw, rh;

    rsa_ram #(.WIDTH(RW), .DEPTH(FREE_ENTRIES)) u_cells (
        .i_clk  (i_clk),
        .i_we   (we),
        .i_waddr(waddr),
        .i_wdata(wdata),
        .i_raddr(raddr),
        .o_rdata(rdata)
    );
    assign {rx, ry, rw, rh} = rdata;

    // Signed extended values for cell-size checks.
    function automatic logic signed [SW-1:0] sx(input logic [COORD_W-1:0] v);
        return $signed({2'b00, v});
    endfunction

    logic signed [SW-1:0] cand_x, cand_y, cand_w, cand_h;
    logic                 keep;
    logic signed [SW-1:0] restw, resth;

    assign restw = sx(r_atlas_w) - sx(r_brush_x);
    assign resth = sx(r_atlas_h) - sx(r_brush_y);

    logic hit_now;
    assign hit_now = r_rd_valid && (rw >= r_w) && (rh >= r_h);

    logic [COORD_W:0] new_by;
    assign new_by = {1'b0, r_brush_y} + {1'b0, r_shelf_h};
    logic [COORD_W-1:0] sat_by;
    assign sat_by = new_by[COORD_W] ? SAT_COORD : new_by[COORD_W-1:0];

    always_comb begin
        cand_x = sx(r_hx);
        cand_y = sx(r_hy) + sx(r_h);
        cand_w = sx(r_w);
        cand_h = sx(r_hh) - sx(r_h);
        if (i_cmd.add_b) begin
            cand_x = sx(r_hx) + sx(r_w);
            cand_y = sx(r_hy);
            cand_w = sx(r_hw) - sx(r_w);
            cand_h = sx(r_hh);
        end else if (i_cmd.shelf_place) begin
            cand_x = sx(r_brush_x);
            cand_y = sx(r_brush_y) + sx(r_h);
            cand_w = sx(r_w);
            cand_h = (r_shelf_open ? sx(r_shelf_h) : sx(r_h)) - sx(r_h);
        end else if (i_cmd.shelf_close) begin
            cand_x = sx(r_brush_x);
            cand_y = sx(r_brush_y);
            cand_w = restw;
            cand_h = sx(r_shelf_h);
        end
        keep = !(cand_w < sx(r_min_free)) && !(cand_h < sx(r_min_free)) && (r_count < FULL);
    end

    logic add_any;
    assign add_any = i_cmd.add_a || i_cmd.add_b || i_cmd.shelf_place || i_cmd.shelf_close;

    always_comb begin
        we    = 1'b0;
        waddr = r_count[AW-1:0];
        wdata = {cand_x[COORD_W-1:0], cand_y[COORD_W-1:0],
                 cand_w[COORD_W-1:0], cand_h[COORD_W-1:0]};
        if (add_any && keep) begin
            we = 1'b1;
        end else if (i_cmd.shift_wr) begin
            we    = 1'b1;
            waddr = r_idx[AW-1:0];
            wdata = rdata;
        end
    end

    // Read address: a scan starts at entry 0 and then walks r_idx;
    // compaction reads entry r_idx + 1.
    logic [CW-1:0] idx_p1;
    assign idx_p1 = r_idx + CW'(1);
    always_comb begin
        raddr = r_idx[AW-1:0];
        if (i_cmd.scan_start) begin
            raddr = '0;
        end else if (i_cmd.shift_rd && idx_p1 < FULL) begin
            raddr = idx_p1[AW-1:0];
        end
    end

    assign o_status.scan_hit         = hit_now;
    assign o_status.scan_end         = !r_rd_valid;
    assign o_status.too_tall         = sx(r_h) > resth;
    assign o_status.fits_shelf       = !(sx(r_w) > restw) && (!r_shelf_open || r_h <= r_shelf_h);
    assign o_status.shelf_open       = r_shelf_open;
    assign o_status.full_after_close = sat_by >= r_atlas_h;
    assign o_status.shift_done       = !(idx_p1 < r_count) || !(idx_p1 < FULL);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_atlas_w    <= COORD_W'(1024);
            r_atlas_h    <= COORD_W'(1024);
            r_min_free   <= COORD_W'(8);
            r_count      <= '0;
            r_brush_x    <= '0;
            r_brush_y    <= '0;
            r_shelf_h    <= '0;
            r_shelf_open <= 1'b0;
            r_rd_valid   <= 1'b0;
            r_idx        <= '0;
            r_granted    <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    CFG_ATLAS_WIDTH:  r_atlas_w  <= i_cfg_data;
                    CFG_ATLAS_HEIGHT: r_atlas_h  <= i_cfg_data;
                    CFG_MIN_FREE:     r_min_free <= i_cfg_data;
                    default:          ;
                endcase
            end
            if (add_any && keep) begin
                r_count <= r_count + CW'(1);
            end
            if (i_cmd.scan_start) begin
                r_idx      <= CW'(1);
                r_rd_valid <= (r_count != '0);
            end else if (i_cmd.scan_step) begin
                r_idx      <= idx_p1;
                r_rd_valid <= (r_idx < r_count) && (r_idx < FULL);
            end
            if (i_cmd.set_grant) begin
                r_idx <= r_hit_idx;
            end
            if (i_cmd.shift_rd && o_status.shift_done) begin
                r_count <= r_count - CW'(1);
            end
            if (i_cmd.shift_wr) begin
                r_idx <= idx_p1;
            end
            if (i_cmd.shelf_place) begin
                if (!r_shelf_open) begin
                    r_shelf_open <= 1'b1;
                    r_shelf_h    <= r_h;
                end
                r_brush_x <= r_brush_x + r_w;
                r_granted <= 1'b1;
                r_left    <= r_brush_x;
                r_top     <= r_brush_y;
            end
            if (i_cmd.shelf_close) begin
                r_brush_x    <= '0;
                r_brush_y    <= sat_by;
                r_shelf_h    <= '0;
                r_shelf_open <= 1'b0;
            end
            if (i_cmd.set_grant) begin
                r_granted <= 1'b1;
                r_left    <= r_hx;
                r_top     <= r_hy;
            end
            if (i_cmd.set_refuse) begin
                r_granted <= 1'b0;
            end
            if (i_cmd.load_req) begin
                r_granted <= 1'b0;
            end
        end
    end

    // Latch the request size on load, and the hit cell; the scan index has already moved one past it.
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_req) begin
            r_w <= i_req_width;
            r_h <= i_req_height;
        end
        if (hit_now && !i_cmd.add_a && !i_cmd.add_b && !i_cmd.shift_rd
            && !i_cmd.shift_wr) begin
            r_hx      <= rx;
            r_hy      <= ry;
            r_hw      <= rw;
            r_hh      <= rh;
            r_hit_idx <= r_idx - CW'(1);
        end
    end

    assign o_granted     = r_granted;
    assign o_left_edge   = r_granted ? r_left : '0;
    assign o_right_edge  = r_granted ? r_left + r_w : '0;
    assign o_top_edge    = r_granted ? r_top : '0;
    assign o_bottom_edge = r_granted ? r_top + r_h : '0;

    assert property (@(posedge i_clk) disable iff (!i_rst_n) r_count <= FULL)
        else $error("free table count overflow");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (add_any && keep) |=> r_count == $past(r_count) + CW'(1))
        else $error("append did not bump count");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_cmd.shelf_place && i_cmd.shelf_close))
        else $error("place and close together");
endmodule
`default_nettype wire

>>> rtl/rectangle_shelf_allocator.sv
// Top level of the rectangle shelf allocator: one request in, one result out.
// A request scans the free cells in turn; a taken cell is followed by compaction of the
// table, and a shelf change adds a second scan. One request in flight; the next is
// accepted in the cycle after the result is taken. The scan runs through one RAM read port.
// Reset (synchronous, active low) empties the table and shelf, loads atlas 1024 x 1024, min 8.
`default_nettype none
module rectangle_shelf_allocator
    import rsa_pkg::*;
#(
    parameter int unsigned FREE_ENTRIES = 32
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_in_valid,
    output logic                    o_in_ready,
    input  wire logic [COORD_W-1:0] i_req_width,
    input  wire logic [COORD_W-1:0] i_req_height,
    output logic                    o_out_valid,
    input  wire logic               i_out_ready,
    output logic                    o_granted,
    output logic [COORD_W-1:0]      o_left_edge,
    output logic [COORD_W-1:0]      o_right_edge,
    output logic [COORD_W-1:0]      o_top_edge,
    output logic [COORD_W-1:0]      o_bottom_edge,
    input  wire logic               i_cfg_valid,
    output logic                    o_cfg_ready,
    input  wire logic [1:0]         i_cfg_index,
    input  wire logic [COORD_W-1:0] i_cfg_data
);
    t_cmd    cmd;
    t_status status;

    assign o_cfg_ready = 1'b1;

    rsa_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .o_out_valid(o_out_valid),
        .i_out_ready(i_out_ready),
        .i_status   (status),
        .o_cmd      (cmd)
    );

    rsa_dpath #(.FREE_ENTRIES(FREE_ENTRIES)) u_dpath (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (cmd),
        .o_status     (status),
        .i_req_width  (i_req_width),
        .i_req_height (i_req_height),
        .i_cfg_we     (i_cfg_valid),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .o_granted    (o_granted),
        .o_left_edge  (o_left_edge),
        .o_right_edge (o_right_edge),
        .o_top_edge   (o_top_edge),
        .o_bottom_edge(o_bottom_edge)
    );
endmodule
`default_nettype wire
